FILE: sv/dpbm_pkg.sv
// Shared types and constants for the dual-port byte memory.
package dpbm_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 4;
  localparam int DATA_W = LANES * BYTE_W;

  localparam logic [SIZE_W-1:0] SIZE_NONE = 4'd0;
  localparam logic [SIZE_W-1:0] SIZE_B1   = 4'd1;
  localparam logic [SIZE_W-1:0] SIZE_B2   = 4'd2;
  localparam logic [SIZE_W-1:0] SIZE_B4   = 4'd4;
  localparam logic [SIZE_W-1:0] SIZE_B8   = 4'd8;

  typedef struct packed {
    logic              read_enable;
    logic [ADDR_W-1:0] read_address;
    logic [SIZE_W-1:0] read_bytes;
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [SIZE_W-1:0] write_bytes;
    logic [DATA_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              access_error;
  } rsp_t;

  // Per-request control carried from decode to the read alignment stage.
  // Bypass bits and data are indexed by bank, not by read lane.
  typedef struct packed {
    logic              error;
    logic [LANE_W-1:0] rd_base;
    logic [SIZE_W-1:0] rd_size;
    logic [LANES-1:0]  bypass;
    logic [DATA_W-1:0] bypass_data;
  } lane_ctl_t;

  function automatic logic size_ok(input logic [SIZE_W-1:0] sz);
    return (sz == SIZE_B1) || (sz == SIZE_B2) || (sz == SIZE_B4) || (sz == SIZE_B8);
  endfunction

endpackage

FILE: sv/dpbm_chan_if.sv
// Valid/ready channel carrying one payload of a chosen type.
interface dpbm_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/dpbm_bank_ram.sv
// One byte-wide bank: one write port and one registered read port.
module dpbm_bank_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [dpbm_pkg::BYTE_W-1:0]   wdata,
  input  logic                          re,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [dpbm_pkg::BYTE_W-1:0]   rdata
);

  logic [dpbm_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Reads return the contents before a same-cycle write; bypass is done outside.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/dpbm_decode.sv
// Request decode: checks, per-bank rows, write enables and bypass detection.
module dpbm_decode #(
  parameter int MEM_BYTES = 1024,
  parameter int ROW_W     = 7
) (
  input  dpbm_pkg::req_t             req,
  output logic [ROW_W-1:0]           rd_row [dpbm_pkg::LANES],
  output logic [ROW_W-1:0]           wr_row [dpbm_pkg::LANES],
  output logic [dpbm_pkg::LANES-1:0] wr_en,
  output dpbm_pkg::lane_ctl_t        ctl
);

  logic [dpbm_pkg::SIZE_W-1:0] rsz;
  logic [dpbm_pkg::SIZE_W-1:0] wsz;
  logic [dpbm_pkg::ADDR_W:0]   rend;
  logic [dpbm_pkg::ADDR_W:0]   wend;
  logic                        rspan_ok;
  logic                        wspan_ok;
  logic                        err;
  logic [dpbm_pkg::LANE_W-1:0] ra3;
  logic [dpbm_pkg::LANE_W-1:0] wa3;
  logic [ROW_W-1:0]            rbase;
  logic [ROW_W-1:0]            wbase;
  logic [dpbm_pkg::LANES-1:0]  rd_used;

  // A disabled port behaves as a port of size zero.
  assign rsz = req.read_enable  ? req.read_bytes  : dpbm_pkg::SIZE_NONE;
  assign wsz = req.write_enable ? req.write_bytes : dpbm_pkg::SIZE_NONE;

  assign rend = {1'b0, req.read_address}  + (dpbm_pkg::ADDR_W + 1)'(rsz);
  assign wend = {1'b0, req.write_address} + (dpbm_pkg::ADDR_W + 1)'(wsz);

  assign rspan_ok = (rsz == dpbm_pkg::SIZE_NONE) ||
                    (rend <= (dpbm_pkg::ADDR_W + 1)'(MEM_BYTES));
  assign wspan_ok = (wsz == dpbm_pkg::SIZE_NONE) ||
                    (wend <= (dpbm_pkg::ADDR_W + 1)'(MEM_BYTES));

  assign err = ((rsz != dpbm_pkg::SIZE_NONE) && !dpbm_pkg::size_ok(rsz)) ||
               ((wsz != dpbm_pkg::SIZE_NONE) && !dpbm_pkg::size_ok(wsz)) ||
               !rspan_ok || !wspan_ok;

  assign ra3   = req.read_address[dpbm_pkg::LANE_W-1:0];
  assign wa3   = req.write_address[dpbm_pkg::LANE_W-1:0];
  assign rbase = req.read_address[ROW_W+dpbm_pkg::LANE_W-1:dpbm_pkg::LANE_W];
  assign wbase = req.write_address[ROW_W+dpbm_pkg::LANE_W-1:dpbm_pkg::LANE_W];

  // Bank b holds the bytes whose address is b modulo eight. An access of up to
  // eight bytes touches each bank at most once; banks below the start offset
  // wrap into the next row.
  always_comb begin
    logic [dpbm_pkg::LANE_W-1:0] rl;
    logic [dpbm_pkg::LANE_W-1:0] wl;
    for (int b = 0; b < dpbm_pkg::LANES; b++) begin
      rl = dpbm_pkg::LANE_W'(b) - ra3;
      wl = dpbm_pkg::LANE_W'(b) - wa3;
      rd_row[b]  = rbase + ROW_W'(dpbm_pkg::LANE_W'(b) < ra3);
      wr_row[b]  = wbase + ROW_W'(dpbm_pkg::LANE_W'(b) < wa3);
      rd_used[b] = {1'b0, rl} < rsz;
      wr_en[b]   = ({1'b0, wl} < wsz) && !err;
      ctl.bypass_data[b*dpbm_pkg::BYTE_W +: dpbm_pkg::BYTE_W] =
        req.write_value[{wl, 3'b000} +: dpbm_pkg::BYTE_W];
      ctl.bypass[b] = rd_used[b] && wr_en[b] && (rd_row[b] == wr_row[b]);
    end
    ctl.error   = err;
    ctl.rd_base = ra3;
    ctl.rd_size = rsz;
  end

endmodule

FILE: sv/dpbm_align.sv
// Read alignment: merges bypass bytes, rotates banks into lanes, masks unused lanes.
module dpbm_align (
  input  dpbm_pkg::lane_ctl_t          ctl,
  input  logic [dpbm_pkg::DATA_W-1:0]  bank_q,
  output dpbm_pkg::rsp_t               rsp
);

  always_comb begin
    logic [dpbm_pkg::LANE_W-1:0] b;
    logic [dpbm_pkg::BYTE_W-1:0] byte_q;
    for (int i = 0; i < dpbm_pkg::LANES; i++) begin
      b = ctl.rd_base + dpbm_pkg::LANE_W'(i);
      byte_q = ctl.bypass[b] ? ctl.bypass_data[{b, 3'b000} +: dpbm_pkg::BYTE_W]
                             : bank_q[{b, 3'b000} +: dpbm_pkg::BYTE_W];
      rsp.read_value[i*dpbm_pkg::BYTE_W +: dpbm_pkg::BYTE_W] =
        ((dpbm_pkg::SIZE_W'(i) < ctl.rd_size) && !ctl.error) ? byte_q : '0;
    end
    rsp.access_error = ctl.error;
  end

endmodule

FILE: sv/dual_port_byte_memory_with_bypass.sv
// Top level: byte-addressed memory with one read and one write per request.
//
//   channel  dir  payload          contents
//   req      in   dpbm_pkg::req_t  read and write port of one request
//   rsp      out  dpbm_pkg::rsp_t  read data and error flag
//
// One request per cycle unless stalled; stage 1 feeds the registered response.
// The memory is eight byte-wide banks, each with one write and one read port;
// write-first bypass is resolved by comparing bank rows at decode.
// After reset a clearing pass zeroes one row of all banks per cycle until every
// row is cleared; during it no request is taken.
// A stalled response holds the pipeline; the request side stays ready while the
// response register can drain.
module dual_port_byte_memory_with_bypass #(
  parameter int MEM_BYTES = 1024
) (
  input logic          clk,
  input logic          rst,
  dpbm_chan_if.sink    req,
  dpbm_chan_if.source  rsp
);

  localparam int ROWS  = (MEM_BYTES + dpbm_pkg::LANES - 1) / dpbm_pkg::LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                         clearing;
  logic [ROW_W-1:0]             clr_row;
  logic                         accept;
  logic                         s1_valid;
  logic                         s1_move;
  dpbm_pkg::lane_ctl_t          s1_ctl;
  logic                         out_valid;
  dpbm_pkg::rsp_t               out_data;

  logic [ROW_W-1:0]             rd_row [dpbm_pkg::LANES];
  logic [ROW_W-1:0]             wr_row [dpbm_pkg::LANES];
  logic [dpbm_pkg::LANES-1:0]   wr_en;
  dpbm_pkg::lane_ctl_t          ctl;
  logic [dpbm_pkg::DATA_W-1:0]  bank_q;
  dpbm_pkg::rsp_t               aligned;

  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!s1_valid || s1_move);
  assign accept    = req.valid && req.ready;

  dpbm_decode #(
    .MEM_BYTES (MEM_BYTES),
    .ROW_W     (ROW_W)
  ) u_decode (
    .req    (req.payload),
    .rd_row (rd_row),
    .wr_row (wr_row),
    .wr_en  (wr_en),
    .ctl    (ctl)
  );

  for (genvar b = 0; b < dpbm_pkg::LANES; b++) begin : g_bank
    dpbm_bank_ram #(
      .DEPTH  (ROWS),
      .ADDR_W (ROW_W)
    ) u_ram (
      .clk   (clk),
      .we    (clearing || (accept && wr_en[b])),
      .waddr (clearing ? clr_row : wr_row[b]),
      .wdata (clearing ? '0 : ctl.bypass_data[b*dpbm_pkg::BYTE_W +: dpbm_pkg::BYTE_W]),
      .re    (accept),
      .raddr (rd_row[b]),
      .rdata (bank_q[b*dpbm_pkg::BYTE_W +: dpbm_pkg::BYTE_W])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
      clr_row <= clr_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl;
    end
  end

  dpbm_align u_align (
    .ctl    (s1_ctl),
    .bank_q (bank_q),
    .rsp    (aligned)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= aligned;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  // No request may be taken while the clearing pass owns the write ports.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("request accepted during clearing pass");

  // A rejected request must not modify memory.
  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.error) |-> (wr_en == '0))
    else $error("write issued for a rejected request");

  // A stage-1 item blocked by a stalled response must still be present next cycle.
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !rsp.ready) |=> s1_valid)
    else $error("stage-1 request lost while response stalled");

  // Leaving reset always starts the clearing pass.
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> clearing)
    else $error("clearing pass not active after reset");

endmodule
